/* rtl/tswm_pkg.sv */
package tswm_pkg;

  // request codes
  localparam logic [1:0] ReqAddDv  = 2'd0;
  localparam logic [1:0] ReqAddDvs = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  // decision codes
  localparam logic [2:0] DecAgree   = 3'd0;
  localparam logic [2:0] DecDvWins  = 3'd1;
  localparam logic [2:0] DecDvsWins = 3'd2;
  localparam logic [2:0] DecDvOnly  = 3'd3;
  localparam logic [2:0] DecDvsOnly = 3'd4;
  localparam logic [2:0] DecNone    = 3'd5;

  // register indexes
  localparam logic CfgWindow = 1'b0;
  localparam logic CfgMaxEnt = 1'b1;

  localparam int unsigned MaxResults  = 16;
  localparam int unsigned NumW        = $clog2(MaxResults + 1);
  localparam int unsigned StaleFactor = 10;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned DetW        = 25;
  localparam int unsigned EntW        = TimeW + DetW;

  // queue entry: time, then {has, class, conf}
  typedef struct packed {
    logic [TimeW-1:0] ts;
    logic             has;
    logic [7:0]       cls;
    logic [15:0]      conf;
  } tswm_ent_t;

  typedef struct packed {
    logic [2:0]       decision;
    logic [7:0]       first_class;
    logic [15:0]      first_conf;
    logic [7:0]       second_class;
    logic [15:0]      second_conf;
    logic [15:0]      mean_conf;
    logic [TimeW-1:0] pair_time;
  } tswm_res_t;

endpackage

/* rtl/tswm_ram.sv */
module tswm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/tswm_fuse.sv */
module tswm_fuse (
  input  tswm_pkg::tswm_ent_t dv_i,
  input  tswm_pkg::tswm_ent_t dvs_i,
  output tswm_pkg::tswm_res_t res_o
);
  import tswm_pkg::*;

  logic [TimeW:0] tsum;
  logic [16:0]    csum;

  assign tsum = {1'b0, dv_i.ts} + {1'b0, dvs_i.ts};
  assign csum = {1'b0, dv_i.conf} + {1'b0, dvs_i.conf};

  always_comb begin
    res_o           = '0;
    res_o.pair_time = tsum[TimeW:1];
    if (dv_i.has && dvs_i.has) begin
      if (dv_i.cls == dvs_i.cls) begin
        res_o.decision    = DecAgree;
        res_o.first_class = dv_i.cls;
        res_o.mean_conf   = csum[16:1];
        res_o.first_conf  = csum[16:1];
      end else if (dv_i.conf > dvs_i.conf) begin
        res_o.decision     = DecDvWins;
        res_o.first_class  = dv_i.cls;
        res_o.first_conf   = dv_i.conf;
        res_o.second_class = dvs_i.cls;
        res_o.second_conf  = dvs_i.conf;
      end else begin
        // equal confidence goes to DVS
        res_o.decision     = DecDvsWins;
        res_o.first_class  = dvs_i.cls;
        res_o.first_conf   = dvs_i.conf;
        res_o.second_class = dv_i.cls;
        res_o.second_conf  = dv_i.conf;
      end
    end else if (dv_i.has) begin
      res_o.decision    = DecDvOnly;
      res_o.first_class = dv_i.cls;
      res_o.first_conf  = dv_i.conf;
    end else if (dvs_i.has) begin
      res_o.decision    = DecDvsOnly;
      res_o.first_class = dvs_i.cls;
      res_o.first_conf  = dvs_i.conf;
    end else begin
      res_o.decision = DecNone;
    end
  end

endmodule

/* rtl/dual_stream_time_window_matcher_core.sv */
// Channel | Direction | Handshake                | Payload
// in      | to core   | in_valid_i / in_stall_o  | req_type, timestamp_ms, detection
// out     | from core | out_valid_o / out_stall_i| fused decision per matched pair
// cfg     | to core   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Add request: when the queue is at its limit, the oldest entry is first dropped by
//   moving each later entry down one place, then the new entry is pushed. A tick walks
//   DV x DVS pairs, one probe at a time, and each match removes both entries by moving
//   the later entries down.
//   Each queue RAM has a single read and write port, so entries move one at a time.
// Reset clears counts and control; queue RAMs are not cleared (counts gate reads).
// A stalled output holds the tick walk; the next request is taken only in idle.
module dual_stream_time_window_matcher_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [47:0] timestamp_ms_i,
  input  logic        has_detection_i,
  input  logic [7:0]  class_id_i,
  input  logic [15:0] confidence_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  decision_o,
  output logic [7:0]  first_class_o,
  output logic [15:0] first_conf_o,
  output logic [7:0]  second_class_o,
  output logic [15:0] second_conf_o,
  output logic [15:0] mean_conf_o,
  output logic [47:0] pair_time_o,
  output logic        last_of_run_o
);
  import tswm_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_SH_RD, S_SH_WR, S_PUSH, S_T_I, S_T_IW, S_T_J, S_T_JW,
    S_T_OUT, S_RM_DV, S_FLUSH, S_ST_DV, S_ST_DVW, S_ST_DVS, S_ST_DVSW
  } state_e;

  state_e       state_q, ret_q;
  logic         sel_q;                 // 0 DV queue, 1 DVS queue
  logic [CW-1:0] pos_q, i_q, j_q, dv_cnt_q, dvs_cnt_q;
  logic [NumW-1:0] n_q;
  logic [15:0]  win_q;
  logic [4:0]   maxe_q;
  tswm_ent_t    new_q, dv_ent_q, dvs_ent_q;
  logic [TimeW-1:0] now_q;
  tswm_res_t    pend_q, out_q, fuse_res;
  logic         pend_v_q, out_v_q, last_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= 16'd50;
      maxe_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindow: win_q  <= cfg_data_i;
        CfgMaxEnt: maxe_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective queue limit, clamped to 1..QUEUE_DEPTH
  logic [LW-1:0] lim_w;
  logic [CW-1:0] lim;
  always_comb begin
    if (maxe_q == 5'd0) lim_w = LW'(1);
    else if (LW'(maxe_q) > LW'(QUEUE_DEPTH)) lim_w = LW'(QUEUE_DEPTH);
    else lim_w = LW'(maxe_q);
  end
  assign lim = CW'(lim_w);

  // queue RAMs
  logic          dv_we, dvs_we;
  logic [AW-1:0] waddr, dv_raddr, dvs_raddr;
  logic [EntW-1:0] wdata, dv_rd, dvs_rd, sh_rd;
  logic [CW-1:0] cnt_cur, pos_nx;
  logic [CW:0]   pos_inc;

  assign cnt_cur = sel_q ? dvs_cnt_q : dv_cnt_q;
  assign pos_inc = {1'b0, pos_q} + (CW+1)'(1);
  assign pos_nx  = pos_inc[CW-1:0];
  assign sh_rd   = sel_q ? dvs_rd : dv_rd;

  always_comb begin
    logic wr;
    wr        = 1'b0;
    waddr     = pos_q[AW-1:0];
    wdata     = sh_rd;
    dv_raddr  = '0;
    dvs_raddr = '0;
    case (state_q)
      S_SH_RD: begin
        dv_raddr  = pos_nx[AW-1:0];
        dvs_raddr = pos_nx[AW-1:0];
      end
      S_SH_WR: wr = 1'b1;
      S_PUSH: begin
        wr    = cnt_cur < CW'(QUEUE_DEPTH);
        waddr = cnt_cur[AW-1:0];
        wdata = new_q;
      end
      S_T_I: dv_raddr  = i_q[AW-1:0];
      S_T_J: dvs_raddr = j_q[AW-1:0];
      default: ;
    endcase
    dv_we  = wr && !sel_q;
    dvs_we = wr && sel_q;
  end

  tswm_ram #(.Width(EntW), .Depth(QUEUE_DEPTH)) u_dv_ram (
    .clk_i, .we_i(dv_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(dv_raddr), .rdata_o(dv_rd)
  );

  tswm_ram #(.Width(EntW), .Depth(QUEUE_DEPTH)) u_dvs_ram (
    .clk_i, .we_i(dvs_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(dvs_raddr), .rdata_o(dvs_rd)
  );

  tswm_fuse u_fuse (.dv_i(dv_ent_q), .dvs_i(dvs_ent_q), .res_o(fuse_res));

  // pairing and stale tests
  tswm_ent_t     dv_rd_e, dvs_rd_e;
  logic [TimeW-1:0] diff, age;
  logic [19:0]   thr;
  logic          in_win, stale, out_free;

  assign dv_rd_e  = dv_rd;
  assign dvs_rd_e = dvs_rd;
  assign diff = (dv_ent_q.ts > dvs_rd_e.ts) ? dv_ent_q.ts - dvs_rd_e.ts
                                            : dvs_rd_e.ts - dv_ent_q.ts;
  assign in_win = diff <= {32'd0, win_q};
  assign thr    = 20'(win_q) * 20'(StaleFactor);
  assign age    = now_q - sh_rd[EntW-1 -: TimeW];
  assign stale  = (now_q > sh_rd[EntW-1 -: TimeW]) && (age > {28'd0, thr});
  assign out_free = !out_v_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      sel_q     <= 1'b0;
      pos_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      dv_cnt_q  <= '0;
      dvs_cnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            new_q <= {timestamp_ms_i, has_detection_i, class_id_i, confidence_i};
            now_q <= timestamp_ms_i;
            unique case (req_type_i) inside
              ReqAddDv, ReqAddDvs: begin
                sel_q <= req_type_i[0];
                pos_q <= '0;
                ret_q <= S_PUSH;
                if ((req_type_i[0] ? dvs_cnt_q : dv_cnt_q) >= lim) state_q <= S_SH_RD;
                else state_q <= S_PUSH;
              end
              ReqTick: begin
                i_q      <= '0;
                n_q      <= '0;
                pend_v_q <= 1'b0;
                state_q  <= S_T_I;
              end
              default: ;
            endcase
          end
        end
        // remove entry at pos_q by moving later entries down one
        S_SH_RD: begin
          if (pos_inc < {1'b0, cnt_cur}) begin
            state_q <= S_SH_WR;
          end else begin
            if (sel_q) dvs_cnt_q <= dvs_cnt_q - CW'(1);
            else dv_cnt_q <= dv_cnt_q - CW'(1);
            state_q <= ret_q;
          end
        end
        S_SH_WR: begin
          pos_q   <= pos_nx;
          state_q <= S_SH_RD;
        end
        S_PUSH: begin
          if (cnt_cur < CW'(QUEUE_DEPTH)) begin
            if (sel_q) dvs_cnt_q <= dvs_cnt_q + CW'(1);
            else dv_cnt_q <= dv_cnt_q + CW'(1);
          end
          state_q <= S_IDLE;
        end
        // tick: outer walk over DV entries
        S_T_I: begin
          if (i_q < dv_cnt_q && n_q < NumW'(MaxResults)) state_q <= S_T_IW;
          else state_q <= S_FLUSH;
        end
        S_T_IW: begin
          dv_ent_q <= dv_rd_e;
          j_q      <= '0;
          state_q  <= S_T_J;
        end
        S_T_J: begin
          if (j_q < dvs_cnt_q) begin
            state_q <= S_T_JW;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_T_I;
          end
        end
        S_T_JW: begin
          if (in_win) begin
            dvs_ent_q <= dvs_rd_e;
            state_q   <= S_T_OUT;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_T_J;
          end
        end
        // hold one match back so the last one of the tick can be flagged
        S_T_OUT: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_q   <= pend_q;
              last_q  <= 1'b0;
              out_v_q <= 1'b1;
            end
            pend_q   <= fuse_res;
            pend_v_q <= 1'b1;
            n_q      <= n_q + NumW'(1);
            sel_q    <= 1'b1;
            pos_q    <= j_q;
            ret_q    <= S_RM_DV;
            state_q  <= S_SH_RD;
          end
        end
        S_RM_DV: begin
          sel_q   <= 1'b0;
          pos_q   <= i_q;
          ret_q   <= S_T_I;
          state_q <= S_SH_RD;
        end
        S_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= S_ST_DV;
          end else if (out_free) begin
            out_q    <= pend_q;
            last_q   <= 1'b1;
            out_v_q  <= 1'b1;
            pend_v_q <= 1'b0;
            state_q  <= S_ST_DV;
          end
        end
        // stale drop at the queue fronts
        S_ST_DV: begin
          sel_q   <= 1'b0;
          pos_q   <= '0;
          state_q <= (dv_cnt_q != '0) ? S_ST_DVW : S_ST_DVS;
        end
        S_ST_DVW: begin
          if (stale) begin
            ret_q   <= S_ST_DV;
            state_q <= S_SH_RD;
          end else begin
            state_q <= S_ST_DVS;
          end
        end
        S_ST_DVS: begin
          sel_q   <= 1'b1;
          pos_q   <= '0;
          state_q <= (dvs_cnt_q != '0) ? S_ST_DVSW : S_IDLE;
        end
        S_ST_DVSW: begin
          if (stale) begin
            ret_q   <= S_ST_DVS;
            state_q <= S_SH_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // front reads in the stale states use address zero (read issued in S_ST_DV/S_ST_DVS)
  assign out_valid_o    = out_v_q;
  assign decision_o     = out_q.decision;
  assign first_class_o  = out_q.first_class;
  assign first_conf_o   = out_q.first_conf;
  assign second_class_o = out_q.second_class;
  assign second_conf_o  = out_q.second_conf;
  assign mean_conf_o    = out_q.mean_conf;
  assign pair_time_o    = out_q.pair_time;
  assign last_of_run_o  = last_q;

endmodule

/* sim/tb_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, keeps a model of the two detection queues and
// compares each fused decision against the oldest prediction.
module tb_checker
  import tswm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [47:0] timestamp_ms_i,
  input  logic        has_detection_i,
  input  logic [7:0]  class_id_i,
  input  logic [15:0] confidence_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  decision_o,
  input  logic [7:0]  first_class_o,
  input  logic [15:0] first_conf_o,
  input  logic [7:0]  second_class_o,
  input  logic [15:0] second_conf_o,
  input  logic [15:0] mean_conf_o,
  input  logic [47:0] pair_time_o,
  input  logic        last_of_run_o,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    tswm_res_t r;
    logic      last;
  } fused_t;

  logic [15:0] window_q;
  logic [4:0]  max_ent_q;
  tswm_ent_t   dv_q[$];
  tswm_ent_t   dvs_q[$];
  fused_t      fused_q[$];

  assign pending_o = fused_q.size();

  function automatic int unsigned fifo_limit();
    if (max_ent_q == 0) return 1;
    if (max_ent_q > QUEUE_DEPTH) return QUEUE_DEPTH;
    return max_ent_q;
  endfunction

  function automatic fused_t fuse_pair(tswm_ent_t v, tswm_ent_t s);
    fused_t f;
    logic [48:0] tsum;
    logic [16:0] csum;
    f = '0;
    csum = v.conf + s.conf;
    if (v.has && s.has) begin
      if (v.cls == s.cls) begin
        f.r.decision = DecAgree;
        f.r.first_class = v.cls;
        f.r.mean_conf = csum[16:1];
        f.r.first_conf = csum[16:1];
      end else if (v.conf > s.conf) begin
        f.r.decision = DecDvWins;
        f.r.first_class = v.cls; f.r.first_conf = v.conf;
        f.r.second_class = s.cls; f.r.second_conf = s.conf;
      end else begin
        f.r.decision = DecDvsWins;
        f.r.first_class = s.cls; f.r.first_conf = s.conf;
        f.r.second_class = v.cls; f.r.second_conf = v.conf;
      end
    end else if (v.has) begin
      f.r.decision = DecDvOnly; f.r.first_class = v.cls; f.r.first_conf = v.conf;
    end else if (s.has) begin
      f.r.decision = DecDvsOnly; f.r.first_class = s.cls; f.r.first_conf = s.conf;
    end else begin
      f.r.decision = DecNone;
    end
    tsum = v.ts + s.ts;
    f.r.pair_time = tsum[48:1];
    return f;
  endfunction

  task automatic push_det(inout tswm_ent_t q[$], input tswm_ent_t e);
    if (q.size() >= fifo_limit()) q.delete(0);
    if (q.size() < QUEUE_DEPTH) q = {q, e};
  endtask

  task automatic drop_old(inout tswm_ent_t q[$], input logic [47:0] now);
    logic [63:0] thr;
    thr = 64'(window_q) * StaleFactor;
    while (q.size() > 0 && now > q[0].ts && 64'(now - q[0].ts) > thr)
      q.delete(0);
  endtask

  task automatic run_tick(input logic [47:0] now);
    int unsigned i, j, n;
    bit hit;
    logic [47:0] d;
    fused_t f;
    i = 0; n = 0;
    while (i < dv_q.size() && n < MaxResults) begin
      hit = 0;
      for (j = 0; j < dvs_q.size(); j++) begin
        d = dv_q[i].ts > dvs_q[j].ts ? dv_q[i].ts - dvs_q[j].ts : dvs_q[j].ts - dv_q[i].ts;
        if (d <= window_q) begin
          f = fuse_pair(dv_q[i], dvs_q[j]);
          fused_q = {fused_q, f};
          n++;
          dvs_q.delete(j);
          hit = 1;
          break;
        end
      end
      if (hit) dv_q.delete(i);
      else i++;
    end
    if (n > 0) fused_q[fused_q.size()-1].last = 1'b1;
    drop_old(dv_q, now);
    drop_old(dvs_q, now);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tswm_ent_t e;
    fused_t    x, act;
    if (!rst_ni) begin
      window_q  = 16'd50;
      max_ent_q = 5'd16;
      dv_q.delete();
      dvs_q.delete();
      fused_q.delete();
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgWindow) window_q = cfg_data_i;
        else max_ent_q = cfg_data_i[4:0];
      end
      if (in_valid_i && !in_stall_o) begin
        e.ts = timestamp_ms_i; e.has = has_detection_i;
        e.cls = class_id_i; e.conf = confidence_i;
        case (req_type_i)
          ReqAddDv:  push_det(dv_q, e);
          ReqAddDvs: push_det(dvs_q, e);
          ReqTick:   run_tick(timestamp_ms_i);
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        act.r = '{decision_o, first_class_o, first_conf_o, second_class_o,
                  second_conf_o, mean_conf_o, pair_time_o};
        act.last = last_of_run_o;
        if (fused_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, act);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          x = fused_q[0];
          fused_q.delete(0);
          if (x !== act) begin
            $display("%0t: mismatch, expected %h actual %h", $time, x, act);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict. Checking lives in tb_checker.
module tb_top;
  import tswm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [47:0] timestamp_ms_i = '0;
  logic        has_detection_i = 1'b0;
  logic [7:0]  class_id_i = '0;
  logic [15:0] confidence_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  decision_o;
  logic [7:0]  first_class_o, second_class_o;
  logic [15:0] first_conf_o, second_conf_o, mean_conf_o;
  logic [47:0] pair_time_o;
  logic        last_of_run_o;
  int          fail_cnt, pending;

  // percent idle per side; changed per phase
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [47:0] now_ms = 48'd1000;

  always #2 clk_i = ~clk_i;

  dual_stream_time_window_matcher_core dut (.*);

  tb_checker chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  // receiver stalls at random
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // valid stays high from one request to the next unless the sender idles
  task automatic send(input logic [1:0] rt, input logic [47:0] ts, input logic h,
                      input logic [7:0] c, input logic [15:0] f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt; timestamp_ms_i <= ts; has_detection_i <= h;
    class_id_i <= c; confidence_i <= f;
    // accepted at the edge where valid is high and stall low
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // quiet point: every result back and the core idle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || in_stall_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // detection near the running clock; small jitter keeps pairs likely
  task automatic rand_det(input logic [1:0] rt, input int unsigned spread);
    send(rt, now_ms + 48'($urandom_range(spread)), $urandom_range(3) != 0,
         8'($urandom_range(3)), 16'($urandom));
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2: rand_det(ReqAddDv, 80);
        3, 4, 5: rand_det(ReqAddDvs, 80);
        6, 7: begin
          now_ms = now_ms + 48'($urandom_range(120));
          send(ReqTick, now_ms + 48'($urandom_range(60)), 1'b0, 8'd0, 16'd0);
        end
        8: send(ReqUnused, 48'({$urandom, $urandom}), 1'($urandom), 8'($urandom),
                16'($urandom));
        default: send(2'($urandom_range(2)), 48'({$urandom, $urandom}), 1'($urandom),
                      8'($urandom), 16'($urandom));
      endcase
      if ($urandom_range(15) == 0) now_ms = now_ms + 48'($urandom_range(3000));
    end
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, all decisions, tie, unused code
    send(ReqAddDv,  48'd0, 1'b1, 8'd5, 16'd100);
    send(ReqAddDvs, 48'd0, 1'b1, 8'd5, 16'd300);       // agree
    send(ReqAddDv,  48'd10, 1'b1, 8'd1, 16'hFFFF);
    send(ReqAddDvs, 48'd20, 1'b1, 8'd2, 16'h0000);     // DV wins
    send(ReqAddDv,  48'd30, 1'b1, 8'd1, 16'd7);
    send(ReqAddDvs, 48'd30, 1'b1, 8'hFF, 16'd7);       // tie: DVS wins
    send(ReqAddDv,  48'd40, 1'b1, 8'd3, 16'd9);
    send(ReqAddDvs, 48'd90, 1'b0, 8'd0, 16'd0);        // DV only, diff = window
    send(ReqAddDv,  48'd95, 1'b0, 8'd0, 16'd0);
    send(ReqAddDvs, 48'd95, 1'b1, 8'd4, 16'd11);       // DVS only
    send(ReqAddDv,  48'd100, 1'b0, 8'd0, 16'd0);
    send(ReqAddDvs, 48'd100, 1'b0, 8'd0, 16'd0);       // none
    send(ReqUnused, '1, 1'b1, 8'hFF, 16'hFFFF);        // ignored
    send(ReqTick, 48'd100, 1'b0, 8'd0, 16'd0);
    send(ReqTick, 48'd200, 1'b0, 8'd0, 16'd0);         // nothing to pair
    send(ReqAddDv,  48'hFFFF_FFFF_FFFF, 1'b1, 8'd1, 16'd1);
    send(ReqAddDvs, 48'hFFFF_FFFF_FFF0, 1'b1, 8'd1, 16'd3);
    send(ReqAddDv,  48'd5, 1'b1, 8'd1, 16'd1);         // stale at the big tick
    send(ReqTick,  48'hFFFF_FFFF_FFFF, 1'b0, 8'd0, 16'd0);
    // overflow: more than the depth in each queue, then a tick that reaches the result cap
    for (k = 0; k < 18; k++)
      send(ReqAddDv, 48'd5000 + 48'(k), 1'b1, 8'(k), 16'(k));
    for (k = 0; k < 18; k++)
      send(ReqAddDvs, 48'd5000 + 48'(k), 1'b1, 8'(k), 16'(100 - k));
    send(ReqTick, 48'd5010, 1'b0, 8'd0, 16'd0);

    // random phases through settings and idling mixes
    write_reg(CfgWindow, 16'd0);
    write_reg(CfgMaxEnt, 16'd0);
    random_phase(30);
    write_reg(CfgWindow, 16'hFFFF);
    write_reg(CfgMaxEnt, 16'h001F);
    idle_pct = 55;
    random_phase(50);
    drain();                                        // sender holds off
    write_reg(CfgWindow, 16'd30);
    write_reg(CfgMaxEnt, 16'd4);
    idle_pct = 0; stall_pct = 55;
    random_phase(60);
    write_reg(CfgMaxEnt, 16'd1);
    idle_pct = 32; stall_pct = 32;
    random_phase(30);
    // lowered limit with full queues
    write_reg(CfgMaxEnt, 16'd16);
    write_reg(CfgWindow, 16'd200);
    idle_pct = 0; stall_pct = 0;
    for (k = 0; k < 16; k++) rand_det(ReqAddDv, 50);
    write_reg(CfgMaxEnt, 16'd3);
    random_phase(50);
    write_reg(CfgWindow, 16'hAAAA);
    write_reg(CfgMaxEnt, 16'h0015);
    idle_pct = 32; stall_pct = 32;
    random_phase(30);
    send(ReqTick, now_ms + 48'd100, 1'b0, 8'd0, 16'd0);

    drain();
    if (fail_cnt == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* dual_stream_time_window_matcher_core.f */
rtl/tswm_pkg.sv
rtl/tswm_ram.sv
rtl/tswm_fuse.sv
rtl/dual_stream_time_window_matcher_core.sv
sim/tb_checker.sv
sim/tb_top.sv
